>>> rtl/lapic_tmr_pkg.sv
// ----------------------------------------------------------------------------
// lapic_tmr_pkg
// Shared types and register offsets for the local interrupt controller timer.
// ----------------------------------------------------------------------------
package lapic_tmr_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    localparam logic [11:0] OFF_TPR  = 12'h080;
    localparam logic [11:0] OFF_EOI  = 12'h0B0;
    localparam logic [11:0] OFF_SPUR = 12'h0F0;
    localparam logic [11:0] OFF_LVT  = 12'h320;
    localparam logic [11:0] OFF_ICR  = 12'h380;
    localparam logic [11:0] OFF_CCR  = 12'h390;
    localparam logic [11:0] OFF_DCR  = 12'h3E0;

    localparam int unsigned SPUR_ENABLE_BIT = 8;
    localparam int unsigned LVT_MASK_BIT    = 16;
    localparam int unsigned LVT_PER_BIT     = 17;

    localparam logic [8:0] SPUR_RESET = 9'h0FF;
    localparam logic [3:0] DCR_MASK   = 4'hB;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] offset;
        logic [31:0] data;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        expired;
        logic        irq_pending;
        logic [7:0]  irq_vector;
    } result_t;

endpackage

>>> rtl/lapic_tmr_core.sv
// ----------------------------------------------------------------------------
// lapic_tmr_core
// Register file, prescaler and down counter; one item handled per fire.
// ----------------------------------------------------------------------------
module lapic_tmr_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  lapic_tmr_pkg::item_t   item,
    output lapic_tmr_pkg::result_t result
);
    import lapic_tmr_pkg::*;

    logic [7:0]  tpr_reg, tpr_next;
    logic [8:0]  spur_reg, spur_next;
    logic [7:0]  lvt_vector_reg, lvt_vector_next;
    logic        lvt_masked_reg, lvt_masked_next;
    logic        lvt_periodic_reg, lvt_periodic_next;
    logic [3:0]  divide_code_reg, divide_code_next;
    logic [31:0] initial_count_reg, initial_count_next;
    logic [31:0] current_count_reg, current_count_next;
    logic [6:0]  prescale_reg, prescale_next;
    logic        pending_reg, pending_next;

    logic [2:0]  div_code;
    logic [2:0]  div_shift;
    logic [7:0]  divisor;
    logic [7:0]  prescale_inc;
    logic [31:0] count_dec;
    logic [31:0] rd;
    logic        exp;

    assign div_code     = {divide_code_reg[3], divide_code_reg[1:0]};
    assign div_shift    = div_code + 3'd1;
    assign divisor      = 8'd1 << div_shift;
    assign prescale_inc = {1'b0, prescale_reg} + 8'd1;
    assign count_dec    = current_count_reg - 32'd1;

    always_comb
    begin
        tpr_next           = tpr_reg;
        spur_next          = spur_reg;
        lvt_vector_next    = lvt_vector_reg;
        lvt_masked_next    = lvt_masked_reg;
        lvt_periodic_next  = lvt_periodic_reg;
        divide_code_next   = divide_code_reg;
        initial_count_next = initial_count_reg;
        current_count_next = current_count_reg;
        prescale_next      = prescale_reg;
        pending_next       = pending_reg;
        rd                 = '0;
        exp                = 1'b0;

        case (item.op)
            OP_READ:
            begin
                case (item.offset)
                    OFF_TPR:  rd = {24'd0, tpr_reg};
                    OFF_SPUR: rd = {23'd0, spur_reg};
                    OFF_LVT:  rd = {14'd0, lvt_periodic_reg, lvt_masked_reg,
                                    8'd0, lvt_vector_reg};
                    OFF_ICR:  rd = initial_count_reg;
                    OFF_CCR:  rd = current_count_reg;
                    OFF_DCR:  rd = {28'd0, divide_code_reg};
                    default:  rd = '0;
                endcase
            end
            OP_WRITE:
            begin
                case (item.offset)
                    OFF_TPR:  tpr_next = item.data[7:0];
                    OFF_EOI:  pending_next = 1'b0;
                    OFF_SPUR: spur_next = item.data[8:0];
                    OFF_LVT:
                    begin
                        lvt_vector_next   = item.data[7:0];
                        lvt_masked_next   = item.data[LVT_MASK_BIT];
                        lvt_periodic_next = item.data[LVT_PER_BIT];
                    end
                    OFF_ICR:
                    begin
                        initial_count_next = item.data;
                        current_count_next = item.data;
                        prescale_next      = '0;
                    end
                    OFF_DCR:  divide_code_next = item.data[3:0] & DCR_MASK;
                    default:  ;
                endcase
            end
            OP_TICK:
            begin
                if (current_count_reg == 32'd0)
                begin
                    prescale_next = '0;
                end
                else if (prescale_inc < divisor)
                begin
                    prescale_next = prescale_inc[6:0];
                end
                else
                begin
                    prescale_next      = '0;
                    current_count_next = count_dec;
                    if (count_dec == 32'd0)
                    begin
                        exp = 1'b1;
                        if (!lvt_masked_reg && spur_reg[SPUR_ENABLE_BIT])
                            pending_next = 1'b1;
                        if (lvt_periodic_reg)
                            current_count_next = initial_count_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        result.read_data   = rd;
        result.expired     = exp;
        result.irq_pending = pending_next;
        result.irq_vector  = pending_next ? lvt_vector_next : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpr_reg           <= '0;
            spur_reg          <= SPUR_RESET;
            lvt_vector_reg    <= '0;
            lvt_masked_reg    <= 1'b1;
            lvt_periodic_reg  <= 1'b0;
            divide_code_reg   <= '0;
            initial_count_reg <= '0;
            current_count_reg <= '0;
            prescale_reg      <= '0;
            pending_reg       <= 1'b0;
        end
        else if (fire)
        begin
            tpr_reg           <= tpr_next;
            spur_reg          <= spur_next;
            lvt_vector_reg    <= lvt_vector_next;
            lvt_masked_reg    <= lvt_masked_next;
            lvt_periodic_reg  <= lvt_periodic_next;
            divide_code_reg   <= divide_code_next;
            initial_count_reg <= initial_count_next;
            current_count_reg <= current_count_next;
            prescale_reg      <= prescale_next;
            pending_reg       <= pending_next;
        end
    end

    a_expire_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.expired) |-> (item.op == OP_TICK))
        else $error("expiry outside a tick");

    a_pending_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pending_reg) |-> ($past(fire) && $past(item.op) == OP_TICK
                                && !$past(lvt_masked_reg)))
        else $error("pending raised without unmasked expiry");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(current_count_reg) && $stable(pending_reg)
                   && $stable(prescale_reg)))
        else $error("state moved without an item");

    a_vector_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (result.irq_vector != 8'd0) |-> result.irq_pending)
        else $error("vector shown while not pending");

endmodule

>>> rtl/local_apic_timer.sv
// ----------------------------------------------------------------------------
// local_apic_timer
// Local interrupt controller timer: register access and bus clock ticks.
// ----------------------------------------------------------------------------
// Result path: an accepted item waits in the input register; its result is
//   registered once the result slot is free, on the edge that advances the core.
// Throughput: one item per cycle; the input register and result register
//   both advance when the result slot is empty or being taken.
// Reset: rst_n sets all timer state to reset values and clears both stages' valid flags.
// ----------------------------------------------------------------------------
module local_apic_timer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [11:0] reg_offset,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        expired,
    output logic        irq_pending,
    output logic [7:0]  irq_vector
);
    import lapic_tmr_pkg::*;

    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t core_result;
    logic    out_free;
    logic    fire;
    logic    in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    lapic_tmr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (s1_item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= '{op: operation, offset: reg_offset, data: write_data};
        if (fire)
            out_result_reg <= core_result;
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = out_result_reg.read_data;
    assign expired     = out_result_reg.expired;
    assign irq_pending = out_result_reg.irq_pending;
    assign irq_vector  = out_result_reg.irq_vector;

endmodule
